// ----- design/tama_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-axis moving average package
// Shared types and fixed widths for the moving-average block and its checker.
// ----------------------------------------------------------------------------
package tama_pkg;

  localparam int AXES     = 3;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 20;
  localparam int QUO_W    = 17;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [QUO_W-1:0]           quo_t;
  typedef logic [AXES-1:0][SAMPLE_W-1:0] row_t;

endpackage

// ----- design/three_axis_moving_average.sv -----
// ----------------------------------------------------------------------------
// Three-axis moving average
// Running-sum moving average over the last WINDOW samples of x, y and z.
// ----------------------------------------------------------------------------
// A request on the input channel carries one signed sample per axis; for each
// request the output channel returns one signed average per axis, the sum of
// the last WINDOW samples divided by WINDOW and truncated toward zero.
// Both channels use valid and ready.
// The sample history lives in one WINDOW-deep memory holding all three axes.
// A request reads its slot, then subtracts the old sample and adds the new one
// to the running sums while it writes the new sample back.
// The division is a multiply by a reciprocal in a stage of its own.
// Stages in order: slot read, running sum, divide, output register.
// Throughput is one request per cycle, unless stalled, set by the single read
// and write port of the history memory, one access of each per request.
// Reset clears the running sums, the slot pointer and the pipeline; slots not
// yet written read as zero through per-slot fill flags.
// When the receiver stalls, results hold in the output register and the
// pipeline keeps accepting until every stage is full, then input ready drops.
// ----------------------------------------------------------------------------
module three_axis_moving_average
  import tama_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample_x,
  input  sample_t in_sample_y,
  input  sample_t in_sample_z,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_average_x,
  output sample_t out_average_y,
  output sample_t out_average_z
);

  localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RECIP_SHIFT = SUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  row_t              mem [WINDOW];
  logic [WINDOW-1:0] filled_r;
  logic [SLOT_W-1:0] slot_r;
  row_t              rd_row_r;
  logic              rd_fill_r;
  logic              fwd_r;
  row_t              fwd_row_r;

  logic              v1_r;
  logic [SLOT_W-1:0] s1_slot_r;
  row_t              s1_row_r;
  sum_t              sum_r [AXES];
  sum_t              sum_nxt [AXES];

  logic              v2_r;
  sum_t              s2_sum_r [AXES];

  logic              v3_r;
  logic [AXES-1:0]   s3_neg_r;
  quo_t              s3_quo_r [AXES];
  quo_t              quo_nxt [AXES];

  logic              vo_r;
  row_t              out_row_r;
  row_t              out_nxt;

  logic rdy_o, rdy3, rdy2, rdy1;
  logic in_acc, wr_en;
  row_t in_row, old_row;

  assign rdy_o  = !vo_r || out_ready;
  assign rdy3   = !v3_r || rdy_o;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign in_acc = in_valid && rdy1;
  assign wr_en  = v1_r && rdy2;

  assign in_ready = rdy1;
  assign in_row   = {in_sample_z, in_sample_y, in_sample_x};
  assign old_row  = fwd_r ? fwd_row_r : (rd_fill_r ? rd_row_r : '0);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_nxt[a] = sum_r[a]
                 - {{(SUM_W-SAMPLE_W){old_row[a][SAMPLE_W-1]}}, old_row[a]}
                 + {{(SUM_W-SAMPLE_W){s1_row_r[a][SAMPLE_W-1]}}, s1_row_r[a]};
    end
  end

  always_comb begin
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      mag        = s2_sum_r[a][SUM_W-1] ? -s2_sum_r[a] : s2_sum_r[a];
      prod       = PROD_W'(mag) * PROD_W'(RECIP);
      quo_nxt[a] = prod[RECIP_SHIFT +: QUO_W];
    end
  end

  always_comb begin
    quo_t res;
    for (int a = 0; a < AXES; a++) begin
      res        = s3_neg_r[a] ? -s3_quo_r[a] : s3_quo_r[a];
      out_nxt[a] = res[SAMPLE_W-1:0];
    end
  end

  // History memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_slot_r] <= s1_row_r;
    end
    if (in_acc) begin
      rd_row_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      filled_r  <= '0;
      rd_fill_r <= 1'b0;
      fwd_r     <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      vo_r      <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      if (in_acc) begin
        slot_r    <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
        rd_fill_r <= filled_r[slot_r];
        fwd_r     <= wr_en && (s1_slot_r == slot_r);
      end
      if (wr_en) begin
        filled_r[s1_slot_r] <= 1'b1;
        for (int a = 0; a < AXES; a++) begin
          sum_r[a] <= sum_nxt[a];
        end
      end
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_o) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_slot_r <= slot_r;
      s1_row_r  <= in_row;
      fwd_row_r <= s1_row_r;
    end
    if (wr_en) begin
      for (int a = 0; a < AXES; a++) begin
        s2_sum_r[a] <= sum_nxt[a];
      end
    end
    if (v2_r && rdy3) begin
      for (int a = 0; a < AXES; a++) begin
        s3_neg_r[a] <= s2_sum_r[a][SUM_W-1];
        s3_quo_r[a] <= quo_nxt[a];
      end
    end
    if (v3_r && rdy_o) begin
      out_row_r <= out_nxt;
    end
  end

  assign out_valid     = vo_r;
  assign out_average_x = out_row_r[0];
  assign out_average_y = out_row_r[1];
  assign out_average_z = out_row_r[2];

endmodule

// ----- design/tama_checker.sv -----
// ----------------------------------------------------------------------------
// Three-axis moving average checker
// Port-level properties of the moving-average block, bound to its top level.
// ----------------------------------------------------------------------------
module tama_checker
  import tama_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_average_x,
  input sample_t out_average_y,
  input sample_t out_average_z
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

  a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Input stalled while the receiver is ready.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("Result missing four cycles after an accepted request.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_x)
      && $stable(out_average_y) && $stable(out_average_z))
    else $error("Stalled result changed.");

endmodule

bind three_axis_moving_average tama_checker u_tama_checker (.*);

// ----- sim/three_axis_moving_average_test.sv -----
// ----------------------------------------------------------------------------
// Three-axis moving average testbench
// Drives sample requests into the three-axis moving average, keeps its own
// ten-deep ring and running sum per axis, and checks every returned average
// in order. A short directed table covers full-scale windows and the first
// results after reset, then random requests follow in phases with idle bursts
// on both channels, one long receiver hold-off, and a quiet final stretch.
// ----------------------------------------------------------------------------
module three_axis_moving_average_test
  import tama_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW      = 10;
  localparam int HOLD_CYCLES = 60;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 100;
  localparam int QUIET_SEGS  = 2;
  localparam int MAX_PRINTS  = 40;

  typedef enum int {
    STYLE_UNIFORM,
    STYLE_MIXED,
    STYLE_FULL_SCALE,
    STYLE_NEAR_ZERO
  } sample_style_e;

  typedef struct packed {
    row_t samples;
    logic typed;
    row_t averages;
  } table_row_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  sample_t in_sample_x;
  sample_t in_sample_y;
  sample_t in_sample_z;
  logic    out_valid;
  logic    out_ready;
  sample_t out_average_x;
  sample_t out_average_y;
  sample_t out_average_z;

  sample_t    ring [AXES][WINDOW];
  int         window_sum [AXES];
  int         write_slot;
  row_t       pending_averages [$];
  table_row_t directed_rows [$];
  int         mismatches;
  int         requests_sent;
  int         averages_checked;
  bit         tx_idle;
  bit         rx_idle;
  bit         hold_req;
  bit         hold_started;
  int         held_cycles;
  bit         seg_negative [AXES];

  three_axis_moving_average #(
    .WINDOW(WINDOW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_x  (in_sample_x),
    .in_sample_y  (in_sample_y),
    .in_sample_z  (in_sample_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_average_x(out_average_x),
    .out_average_y(out_average_y),
    .out_average_z(out_average_z)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic row_t advance_window(row_t samples);
    row_t averages;
    sample_t s;
    for (int a = 0; a < AXES; a++) begin
      s = sample_t'(samples[a]);
      window_sum[a] = window_sum[a] - int'(ring[a][write_slot]) + int'(s);
      ring[a][write_slot] = s;
      averages[a] = sample_t'(window_sum[a] / WINDOW);
    end
    write_slot = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
    return averages;
  endfunction

  function automatic table_row_t mk_row(int x, int y, int z, bit typed = 1'b0,
                                        int ax = 0, int ay = 0, int az = 0);
    table_row_t r;
    r.samples  = {sample_t'(z), sample_t'(y), sample_t'(x)};
    r.typed    = typed;
    r.averages = {sample_t'(az), sample_t'(ay), sample_t'(ax)};
    return r;
  endfunction

  function automatic sample_t pick_sample(sample_style_e style, int axis);
    sample_t s;
    case (style)
      STYLE_UNIFORM: begin
        s = sample_t'($urandom);
      end
      STYLE_MIXED: begin
        case ($urandom_range(0, 5))
          0:       s = 16'sh7fff;
          1:       s = 16'sh8000;
          2:       s = sample_t'($urandom_range(0, 40) - 20);
          default: s = sample_t'($urandom);
        endcase
      end
      STYLE_FULL_SCALE: begin
        if ($urandom_range(0, 15) == 0) begin
          s = sample_t'($urandom);
        end else begin
          s = seg_negative[axis] ? 16'sh8000 : 16'sh7fff;
        end
      end
      default: begin
        s = sample_t'($urandom_range(0, 62) - 31);
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("ERROR t=%0t %s", $realtime, msg);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(row_t samples, bit typed, row_t averages);
    row_t predicted;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_sample_x = sample_t'(samples[0]);
    in_sample_y = sample_t'(samples[1]);
    in_sample_z = sample_t'(samples[2]);
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = advance_window(samples);
    pending_averages.push_back(typed ? averages : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
        held_cycles++;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_output
    row_t got;
    row_t want;
    string axis_name [AXES];
    axis_name = '{"average_x", "average_y", "average_z"};
    if (rst_n && out_valid && out_ready) begin
      got = {out_average_z, out_average_y, out_average_x};
      if (pending_averages.size() == 0) begin
        report_mismatch("unexpected result with no request outstanding");
      end else begin
        want = pending_averages.pop_front();
        averages_checked++;
        for (int a = 0; a < AXES; a++) begin
          if (got[a] !== want[a]) begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", axis_name[a],
                                      sample_t'(got[a]), sample_t'(want[a])));
          end
        end
      end
    end
  end

  initial begin : stimulus
    row_t samples;
    sample_style_e style;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample_x = '0;
    in_sample_y = '0;
    in_sample_z = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_req    = 1'b0;
    hold_started = 1'b0;
    held_cycles = 0;
    mismatches  = 0;
    requests_sent    = 0;
    averages_checked = 0;
    write_slot  = 0;
    for (int a = 0; a < AXES; a++) begin
      window_sum[a] = 0;
      for (int i = 0; i < WINDOW; i++) ring[a][i] = '0;
    end

    // Full-scale windows in both directions, then a sign swap across the wrap.
    directed_rows.push_back(mk_row(32767, -32768, -32768, 1, 3276, -3276, -3276));
    for (int i = 0; i < 8; i++) directed_rows.push_back(mk_row(32767, -32768, -32768));
    directed_rows.push_back(mk_row(32767, -32768, -32768, 1, 32767, -32768, -32768));
    for (int i = 0; i < 9; i++) directed_rows.push_back(mk_row(-32768, 32767, 0));
    directed_rows.push_back(mk_row(-32768, 32767, 0, 1, -32768, 32767, 0));
    directed_rows.push_back(mk_row(-1, 1, -9));
    directed_rows.push_back(mk_row(0, 0, 0));
    directed_rows.push_back(mk_row(1, -1, 9));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].samples, directed_rows[i].typed,
                   directed_rows[i].averages);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      style = sample_style_e'($urandom_range(0, 3));
      for (int a = 0; a < AXES; a++) seg_negative[a] = $urandom_range(0, 1);
      tx_idle = (seg < SEGMENTS - QUIET_SEGS) && ($urandom_range(0, 3) != 0);
      rx_idle = (seg < SEGMENTS - QUIET_SEGS) && ($urandom_range(0, 3) != 0);
      if (seg == 1) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      for (int k = 0; k < SEG_ITEMS; k++) begin
        for (int a = 0; a < AXES; a++) samples[a] = pick_sample(style, a);
        send_request(samples, 1'b0, '0);
      end
    end
    in_valid = 1'b0;

    while (pending_averages.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d sample requests (%0d from the directed table), %0d %s",
             requests_sent, directed_rows.size(), averages_checked, "averages checked.");
    $display("Receiver held off for %0d cycles once; %s", held_cycles,
             "idle bursts hit both channels in most phases.");
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tama_pkg.sv
design/three_axis_moving_average.sv
design/tama_checker.sv
sim/three_axis_moving_average_test.sv
